// ===== hw/rtl/wnm_pkg.sv =====
// shared sizes, character codes, types and helpers of the wildcard name matcher
package wnm_pkg;

	localparam int MAX_PATTERN = 64;
	localparam int MAX_NAME = 256;

	localparam int CHAR_W = 8;
	localparam int ACTION_W = 2;

	localparam int PAT_CNT_W = $clog2(MAX_PATTERN + 1);
	localparam int NAME_CNT_W = $clog2(MAX_NAME + 1);
	localparam int NAME_AW = (MAX_NAME > 1) ? $clog2(MAX_NAME) : 1;

	localparam logic [CHAR_W-1:0] CH_ONE = 8'h3F;
	localparam logic [CHAR_W-1:0] CH_ANY = 8'h2A;
	localparam logic [CHAR_W-1:0] CH_DOT = 8'h2E;

	localparam logic [CHAR_W-1:0] UPPER_FIRST = 8'h41;
	localparam logic [CHAR_W-1:0] UPPER_LAST = 8'h5A;
	localparam logic [CHAR_W-1:0] CASE_OFFSET = 8'h20;

	typedef enum logic [ACTION_W-1:0] {
		ACT_CLEAR   = 2'd0,
		ACT_PATTERN = 2'd1,
		ACT_NAME    = 2'd2,
		ACT_END     = 2'd3
	} action_t;

	typedef enum logic {
		ST_IDLE,
		ST_EVAL
	} state_t;

	// broadcast controls for the cell row
	typedef struct packed {
		logic clear;
		logic append;
		logic tail_char;
		logic init;
		logic step;
	} cell_ctl_t;

	// what one cell hands to its right-hand neighbor
	typedef struct packed {
		logic taken;
		logic st;
		logic pre;
	} cell_link_t;

	// ascii upper case folds to lower case, everything else unchanged
	function automatic logic [CHAR_W-1:0] fold(input logic [CHAR_W-1:0] c);
		if (c >= UPPER_FIRST && c <= UPPER_LAST) begin
			return c + CASE_OFFSET;
		end
		return c;
	endfunction

endpackage

// ===== hw/rtl/wnm_in_if.sv =====
// input channel of the wildcard name matcher: action and character
interface wnm_in_if import wnm_pkg::*; ();
	logic                valid;
	logic                ready;
	logic [ACTION_W-1:0] action;
	logic [CHAR_W-1:0]   char_code;

	modport source (output valid, output action, output char_code, input ready);
	modport sink (input valid, input action, input char_code, output ready);
endinterface

// ===== hw/rtl/wnm_out_if.sv =====
// result channel of the wildcard name matcher: match and overflow flags
interface wnm_out_if ();
	logic valid;
	logic ready;
	logic is_match;
	logic overflowed;

	modport source (output valid, output is_match, output overflowed, input ready);
	modport sink (input valid, input is_match, input overflowed, output ready);
endinterface

// ===== hw/rtl/wnm_ram.sv =====
// generic single-port-write, registered-read ram
module wnm_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             wr_en,
	input  logic [AW-1:0]    wr_addr,
	input  logic [WIDTH-1:0] wr_data,
	input  logic             rd_en,
	input  logic [AW-1:0]    rd_addr,
	output logic [WIDTH-1:0] rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

// ===== hw/rtl/wnm_cell.sv =====
// one pattern position: stored character, occupancy, tail mask and match state
module wnm_cell import wnm_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  cell_ctl_t         ctl,
	input  logic [CHAR_W-1:0] pat_char,
	input  logic [CHAR_W-1:0] name_char,
	input  cell_link_t        left,
	output cell_link_t        right,
	output logic              hit
);

	logic              taken_q;
	logic              mask_q;
	logic              st_q;
	logic [CHAR_W-1:0] pc_q;

	logic wr_here;
	logic is_star;
	logic is_one;
	logic same;
	logic pre;
	logic pre_eff;
	logic st_d;

	// first free cell takes the appended character
	assign wr_here = ctl.append & left.taken & ~taken_q;

	assign is_star = (pc_q == CH_ANY);
	assign is_one  = (pc_q == CH_ONE);
	assign same    = (fold(pc_q) == fold(name_char));

	// state before star closure: advance from left, or a star swallows the char
	assign pre     = (left.st & ~is_star & (is_one | same)) | (st_q & is_star);
	assign pre_eff = ctl.init ? 1'b0 : pre;
	// a star may also match nothing: pass the left position through
	assign st_d    = pre_eff | (left.pre & is_star);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			taken_q <= 1'b0;
			mask_q  <= 1'b0;
			st_q    <= 1'b0;
		end else begin
			if (ctl.clear) begin
				taken_q <= 1'b0;
				mask_q  <= 1'b0;
			end else if (wr_here) begin
				taken_q <= 1'b1;
				mask_q  <= 1'b1;
			end else if (ctl.append && taken_q && !ctl.tail_char) begin
				mask_q <= 1'b0;
			end
			if (ctl.init || ctl.step) begin
				st_q <= st_d;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (wr_here) begin
			pc_q <= pat_char;
		end
	end

	assign right = '{taken: taken_q, st: st_q, pre: pre_eff};
	assign hit   = st_q & mask_q;

endmodule

// ===== hw/rtl/wildcard_name_match.sv =====
// top level of the wildcard name matcher: control, name ram and the cell row
// clear, pattern and name transfers are taken one per cycle while no name is being matched
// an end transfer feeds the stored name through the cell row, then registers the result once the output is free
// the cell row takes one name byte a cycle from the name ram
// no input is taken while a name is being matched
// reset empties pattern and name, clears the overflow flag; the stores keep old data
module wildcard_name_match import wnm_pkg::*; (
	input logic      clk,
	input logic      arst_n,
	wnm_in_if.sink   item,
	wnm_out_if.source result
);

	// control registers
	state_t                 state_q;
	state_t                 state_d;
	logic [PAT_CNT_W-1:0]   pcnt_q;       // pattern chars taken, counting collapsed stars
	logic                   last_star_q;  // last pattern char was a star
	logic [NAME_CNT_W-1:0]  nlen_q;       // name chars stored
	logic                   ovf_q;        // sticky drop flag
	logic                   a0_q;         // match state of the empty pattern prefix
	logic                   mask0_q;      // empty prefix is followed by tail chars only
	logic [NAME_CNT_W-1:0]  rem_q;        // name chars still to feed
	logic [NAME_AW-1:0]     rd_ptr_q;

	// output register
	logic out_valid_q;
	logic match_q;
	logic out_ovf_q;

	action_t               act;
	logic                  in_fire;
	logic                  is_any_c;
	logic                  tail_c;
	logic                  pat_fire;
	logic                  pat_room;
	logic                  pat_store;
	logic                  name_fire;
	logic                  name_room;
	logic                  name_wr;
	logic                  clear_fire;
	logic                  end_fire;
	logic                  feeding;
	logic                  out_free;
	logic                  finish;
	logic [NAME_AW-1:0]    rd_addr;
	logic [CHAR_W-1:0]     name_char;
	logic                  hit_any;

	cell_ctl_t                 ctl;
	cell_link_t                link [MAX_PATTERN+1];
	logic [MAX_PATTERN-1:0]    hits;
	logic [MAX_PATTERN-1:0]    taken_vec;

	// input decode
	assign act       = action_t'(item.action);
	assign item.ready = (state_q == ST_IDLE);
	assign in_fire   = item.valid & item.ready;

	assign is_any_c  = (item.char_code == CH_ANY);
	assign tail_c    = is_any_c | (item.char_code == CH_DOT);

	assign clear_fire = in_fire && (act == ACT_CLEAR);
	assign pat_fire   = in_fire && (act == ACT_PATTERN);
	assign name_fire  = in_fire && (act == ACT_NAME);
	assign end_fire   = in_fire && (act == ACT_END);

	assign pat_room  = (pcnt_q < PAT_CNT_W'(MAX_PATTERN));
	// a star right after a star is counted but not stored: one cell per star run
	assign pat_store = pat_fire && pat_room && !(is_any_c && last_star_q);
	assign name_room = (nlen_q < NAME_CNT_W'(MAX_NAME));
	assign name_wr   = name_fire && name_room;

	// evaluation: one name byte per cycle into the row, then the tail check
	assign feeding  = (state_q == ST_EVAL) && (rem_q != '0);
	assign out_free = !out_valid_q || result.ready;
	assign finish   = (state_q == ST_EVAL) && (rem_q == '0) && out_free;

	// the end transfer starts the read of the first name byte
	assign rd_addr = end_fire ? '0 : rd_ptr_q;

	wnm_ram #(
		.WIDTH (CHAR_W),
		.DEPTH (MAX_NAME)
	) u_name_ram (
		.clk     (clk),
		.wr_en   (name_wr),
		.wr_addr (nlen_q[NAME_AW-1:0]),
		.wr_data (item.char_code),
		.rd_en   (end_fire | feeding),
		.rd_addr (rd_addr),
		.rd_data (name_char)
	);

	// row controls, broadcast to every cell
	assign ctl = '{
		clear:     clear_fire,
		append:    pat_store,
		tail_char: tail_c,
		init:      end_fire,
		step:      feeding
	};

	// left end of the row: always occupied, empty-prefix state, seed on init
	assign link[0] = '{taken: 1'b1, st: a0_q, pre: end_fire};

	for (genvar i = 0; i < MAX_PATTERN; i++) begin : g_cell
		wnm_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.ctl       (ctl),
			.pat_char  (item.char_code),
			.name_char (name_char),
			.left      (link[i]),
			.right     (link[i+1]),
			.hit       (hits[i])
		);
		assign taken_vec[i] = link[i+1].taken;
	end

	// the name matches if any live position is followed only by tail chars
	assign hit_any = (a0_q & mask0_q) | (|hits);

	// state machine
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (end_fire) begin
					state_d = ST_EVAL;
				end
			end
			ST_EVAL: begin
				if (finish) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// pattern, name and evaluation bookkeeping
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pcnt_q      <= '0;
			last_star_q <= 1'b0;
			nlen_q      <= '0;
			ovf_q       <= 1'b0;
			a0_q        <= 1'b0;
			mask0_q     <= 1'b1;
			rem_q       <= '0;
			rd_ptr_q    <= '0;
		end else begin
			if (clear_fire) begin
				pcnt_q      <= '0;
				last_star_q <= 1'b0;
				mask0_q     <= 1'b1;
			end else if (pat_fire && pat_room) begin
				pcnt_q      <= pcnt_q + PAT_CNT_W'(1);
				last_star_q <= is_any_c;
				if (!tail_c) begin
					mask0_q <= 1'b0;
				end
			end

			// sticky until the pattern is cleared
			if (clear_fire) begin
				ovf_q <= 1'b0;
			end else if ((pat_fire && !pat_room) || (name_fire && !name_room)) begin
				ovf_q <= 1'b1;
			end

			if (end_fire) begin
				nlen_q   <= '0;
				rem_q    <= nlen_q;
				rd_ptr_q <= NAME_AW'(1);
				a0_q     <= 1'b1;
			end else if (feeding) begin
				rem_q    <= rem_q - NAME_CNT_W'(1);
				rd_ptr_q <= rd_ptr_q + NAME_AW'(1);
				a0_q     <= 1'b0;
			end else if (name_wr) begin
				nlen_q <= nlen_q + NAME_CNT_W'(1);
			end
		end
	end

	// result register: holds the result until its transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (finish) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (finish) begin
			match_q   <= hit_any;
			out_ovf_q <= ovf_q;
		end
	end

	assign result.valid      = out_valid_q;
	assign result.is_match   = match_q;
	assign result.overflowed = out_ovf_q;

	// an end transfer starts an evaluation over exactly the stored name
	a_end_loads: assert property (@(posedge clk) disable iff (!arst_n)
		end_fire |=> (state_q == ST_EVAL) && (rem_q == $past(nlen_q)))
		else $error("evaluation did not start with the stored name length");

	// cells fill from the left with no gaps
	a_fill_order: assert property (@(posedge clk) disable iff (!arst_n)
		((taken_vec >> 1) & ~taken_vec) == '0)
		else $error("cell row occupancy has a gap");

	// stored cells never outnumber the pattern chars taken
	a_fill_count: assert property (@(posedge clk) disable iff (!arst_n)
		$countones(taken_vec) <= pcnt_q)
		else $error("more cells occupied than pattern chars taken");

	// a finished evaluation shows up at the output with the current overflow flag
	a_finish_out: assert property (@(posedge clk) disable iff (!arst_n)
		finish |=> result.valid && (result.overflowed == $past(ovf_q)))
		else $error("finished evaluation not presented at the output");

endmodule

// ===== verif/wildcard_name_match_tb.sv =====
// testbench for the wildcard name matcher: directed table, random glob sequences, scoreboard
`timescale 1ns / 100ps

module wildcard_name_match_tb;
	import wnm_pkg::*;

	// run length and watchdog
	localparam int RANDOM_ITEMS = 1000;
	localparam int CYCLE_LIMIT = 400000;
	localparam int DRAIN_CYCLES = MAX_NAME + 16;

	// one match outcome as the result channel carries it
	typedef struct packed {
		logic is_match;
		logic overflowed;
	} match_flags_t;

	// one line of the directed table, repeated reps times
	typedef struct {
		action_t    act;
		logic [7:0] ch;
		int         reps;
		bit         typed;
		bit         want_match;
		bit         want_ovf;
	} glob_row_t;

	logic clk;
	logic arst_n;

	wnm_in_if  item_ch ();
	wnm_out_if result_ch ();

	wildcard_name_match dut (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (item_ch),
		.result (result_ch)
	);

	// shadow copy of the matcher state, advanced on every accepted transfer
	logic [7:0] pat_mem [MAX_PATTERN];
	int         pat_cnt;
	logic [7:0] nm_mem [MAX_NAME];
	int         nm_cnt;
	bit         ovf_sticky;

	// outcomes still owed by the dut, oldest first
	match_flags_t pending_flags [$];

	int mismatches;
	int items_sent;
	int cycle_count;
	int send_idle_pct;
	int recv_stall_pct;

	glob_row_t glob_rows [$];

	// free-running clock, 20 ns period
	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// watchdog: a hung handshake or a lost result ends the run here
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("wildcard_name_match verification failed");
			$finish;
		end
	end

	// ascii letters compare without case, high bytes only to themselves
	function automatic logic [7:0] to_lower(input logic [7:0] c);
		if (c >= 8'h41 && c <= 8'h5A) begin
			return c + 8'h20;
		end
		return c;
	endfunction

	// greedy glob walk with a single star resume point
	function automatic bit glob_hit();
		int pi;
		int ni;
		int resume_pi;
		int resume_ni;
		bit star_seen;
		pi = 0;
		ni = 0;
		resume_pi = 0;
		resume_ni = 0;
		star_seen = 1'b0;
		while (ni < nm_cnt) begin
			if (pi < pat_cnt && pat_mem[pi] == CH_ANY) begin
				// a run of stars collapses to one resume point
				while (pi < pat_cnt && pat_mem[pi] == CH_ANY) begin
					pi++;
				end
				star_seen = 1'b1;
				resume_pi = pi;
				resume_ni = ni;
			end else if (pi < pat_cnt && (pat_mem[pi] == CH_ONE ||
					to_lower(pat_mem[pi]) == to_lower(nm_mem[ni]))) begin
				pi++;
				ni++;
			end else if (star_seen) begin
				// let the last star swallow one more name byte and retry
				resume_ni++;
				ni = resume_ni;
				pi = resume_pi;
			end else begin
				return 1'b0;
			end
		end
		// name used up: trailing dots and stars may match the empty end
		while (pi < pat_cnt && (pat_mem[pi] == CH_DOT || pat_mem[pi] == CH_ANY)) begin
			pi++;
		end
		return pi == pat_cnt;
	endfunction

	// advance the shadow state by one transfer; returns 1 when an outcome is due
	function automatic bit glob_apply(input action_t act, input logic [7:0] ch,
			output match_flags_t flags);
		flags = '0;
		case (act)
			ACT_CLEAR: begin
				pat_cnt = 0;
				ovf_sticky = 1'b0;
			end
			ACT_PATTERN: begin
				if (pat_cnt < MAX_PATTERN) begin
					pat_mem[pat_cnt] = ch;
					pat_cnt++;
				end else begin
					ovf_sticky = 1'b1;
				end
			end
			ACT_NAME: begin
				if (nm_cnt < MAX_NAME) begin
					nm_mem[nm_cnt] = ch;
					nm_cnt++;
				end else begin
					ovf_sticky = 1'b1;
				end
			end
			default: begin
				// end of name
				flags.is_match = glob_hit();
				flags.overflowed = ovf_sticky;
				// the name empties, the pattern and the sticky flag stay
				nm_cnt = 0;
				return 1'b1;
			end
		endcase
		return 1'b0;
	endfunction

	task automatic report_mismatch(input string what, input int got, input int want);
		$display("[%0t] mismatch on %s: got %0d, want %0d", $time, what, got, want);
		mismatches++;
	endtask

	// offer one transfer from a falling edge, wait for it to be taken,
	// then update the shadow state; typed rows override the predicted outcome
	task automatic send_item(input action_t act, input logic [7:0] ch, input bit typed,
			input bit want_match, input bit want_ovf);
		match_flags_t flags;
		bit due;
		while ($urandom_range(0, 99) < send_idle_pct) begin
			item_ch.valid <= 1'b0;
			@(negedge clk);
		end
		item_ch.valid <= 1'b1;
		item_ch.action <= act;
		item_ch.char_code <= ch;
		@(posedge clk);
		while (!item_ch.ready) begin
			@(posedge clk);
		end
		due = glob_apply(act, ch, flags);
		if (due) begin
			if (typed) begin
				flags.is_match = want_match;
				flags.overflowed = want_ovf;
			end
			pending_flags.push_back(flags);
		end
		items_sent++;
		@(negedge clk);
	endtask

	// hold the input channel quiet until every owed outcome has come back
	task automatic drain_pending();
		item_ch.valid <= 1'b0;
		while (pending_flags.size() != 0) begin
			@(negedge clk);
		end
	endtask

	// pattern bytes lean on wildcards and a few letters so names can match
	function automatic logic [7:0] pick_pattern_char();
		case ($urandom_range(0, 11))
			0, 1: return CH_ANY;
			2: return CH_ONE;
			3: return CH_DOT;
			4: return 8'h61;
			5: return 8'h62;
			6: return 8'h41;
			7: return 8'h42;
			8: return $urandom_range(0, 1) ? 8'hC1 : 8'hE1;
			default: return 8'($urandom_range(0, 255));
		endcase
	endfunction

	function automatic logic [7:0] pick_name_char();
		case ($urandom_range(0, 9))
			0: return 8'h61;
			1: return 8'h62;
			2: return 8'h41;
			3: return 8'h42;
			4: return CH_DOT;
			5: return $urandom_range(0, 1) ? 8'hC1 : 8'hE1;
			default: return 8'($urandom_range(0, 255));
		endcase
	endfunction

	// mostly a name shaped by the pattern, sometimes mutated, rarely a long random one
	task automatic build_name(ref logic [7:0] pat_q [$], ref logic [7:0] nm_q [$]);
		logic [7:0] c;
		int pos;
		nm_q = {};
		if ($urandom_range(0, 99) < 3) begin
			// from six bytes short of to six bytes past the name store
			repeat ($urandom_range(MAX_NAME - 6, MAX_NAME + 6)) begin
				nm_q.push_back(pick_name_char());
			end
			return;
		end
		foreach (pat_q[k]) begin
			c = pat_q[k];
			if (c == CH_ANY) begin
				repeat ($urandom_range(0, 3)) begin
					nm_q.push_back(pick_name_char());
				end
			end else if (c == CH_ONE) begin
				nm_q.push_back(pick_name_char());
			end else begin
				// flip the case of letters now and then
				if ((c | 8'h20) >= 8'h61 && (c | 8'h20) <= 8'h7A && $urandom_range(0, 1)) begin
					c = c ^ 8'h20;
				end
				nm_q.push_back(c);
			end
		end
		if ($urandom_range(0, 99) < 30) begin
			pos = nm_q.size() == 0 ? 0 : $urandom_range(0, nm_q.size() - 1);
			case ($urandom_range(0, 2))
				0: if (nm_q.size() != 0) begin
					nm_q[pos] = pick_name_char();
				end
				1: if (nm_q.size() != 0) begin
					nm_q.delete(pos);
				end
				default: nm_q.insert(pos, pick_name_char());
			endcase
		end
	endtask

	// one session: an occasional stray burst, a pattern usually after a clear, then a few names each closed by an end
	task automatic run_session();
		logic [7:0] pat_q [$];
		logic [7:0] nm_q [$];
		int plen;
		pat_q = {};
		// a stray burst of arbitrary transfers now and then
		if ($urandom_range(0, 9) == 0) begin
			repeat ($urandom_range(1, 6)) begin
				send_item(action_t'($urandom_range(0, 3)), 8'($urandom_range(0, 255)),
					1'b0, 1'b0, 1'b0);
			end
		end
		// a few sessions keep the old pattern and sticky flag and just append
		if ($urandom_range(0, 9) != 0) begin
			send_item(ACT_CLEAR, 8'($urandom_range(0, 255)), 1'b0, 1'b0, 1'b0);
		end
		plen = ($urandom_range(0, 99) < 4) ? $urandom_range(MAX_PATTERN - 4, MAX_PATTERN + 6)
			: $urandom_range(0, 8);
		repeat (plen) begin
			pat_q.push_back(pick_pattern_char());
		end
		foreach (pat_q[k]) begin
			send_item(ACT_PATTERN, pat_q[k], 1'b0, 1'b0, 1'b0);
		end
		repeat ($urandom_range(1, 4)) begin
			build_name(pat_q, nm_q);
			foreach (nm_q[k]) begin
				send_item(ACT_NAME, nm_q[k], 1'b0, 1'b0, 1'b0);
			end
			send_item(ACT_END, 8'($urandom_range(0, 255)), 1'b0, 1'b0, 1'b0);
		end
	endtask

	// receiver: ready changes at the falling edge, stalls at the phase's rate
	always @(negedge clk) begin
		result_ch.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
	end

	// scoreboard: every result transfer is matched with the oldest outcome owed
	always @(posedge clk) begin : check_results
		match_flags_t want;
		if (arst_n && result_ch.valid && result_ch.ready) begin
			if (pending_flags.size() == 0) begin
				report_mismatch("unexpected result transfer", 1, 0);
			end else begin
				want = pending_flags.pop_front();
				if (result_ch.is_match !== want.is_match) begin
					report_mismatch("is_match", result_ch.is_match, want.is_match);
				end
				if (result_ch.overflowed !== want.overflowed) begin
					report_mismatch("overflowed", result_ch.overflowed, want.overflowed);
				end
			end
		end
	end

	initial begin : stimulus
		int phase_end;
		int rand_base;
		// known levels on every input from time zero
		arst_n = 1'b0;
		item_ch.valid = 1'b0;
		item_ch.action = ACT_CLEAR;
		item_ch.char_code = 8'h00;
		result_ch.ready = 1'b0;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		mismatches = 0;
		items_sent = 0;
		cycle_count = 0;
		pat_cnt = 0;
		nm_cnt = 0;
		ovf_sticky = 1'b0;

		// directed table: typed outcomes only where they are obvious
		glob_rows = '{
			// empty name against empty pattern right after reset
			'{ACT_END,     8'h00, 1,   1'b1, 1'b1, 1'b0},
			// empty pattern rejects any non-empty name
			'{ACT_NAME,    8'h78, 1,   1'b0, 1'b0, 1'b0},
			'{ACT_END,     8'hFF, 1,   1'b1, 1'b0, 1'b0},
			// empty name against a pattern of only star and dot
			'{ACT_PATTERN, CH_ANY, 1,  1'b0, 1'b0, 1'b0},
			'{ACT_PATTERN, CH_DOT, 1,  1'b0, 1'b0, 1'b0},
			'{ACT_END,     8'h00, 1,   1'b1, 1'b1, 1'b0},
			// pattern "A?**z" plus a high byte, name "aQrsZ" plus the same byte
			'{ACT_CLEAR,   8'hA5, 1,   1'b0, 1'b0, 1'b0},
			'{ACT_PATTERN, 8'h41, 1,   1'b0, 1'b0, 1'b0},
			'{ACT_PATTERN, CH_ONE, 1,  1'b0, 1'b0, 1'b0},
			'{ACT_PATTERN, CH_ANY, 2,  1'b0, 1'b0, 1'b0},
			'{ACT_PATTERN, 8'h7A, 1,   1'b0, 1'b0, 1'b0},
			'{ACT_PATTERN, 8'hFF, 1,   1'b0, 1'b0, 1'b0},
			'{ACT_NAME,    8'h61, 1,   1'b0, 1'b0, 1'b0},
			'{ACT_NAME,    8'h51, 1,   1'b0, 1'b0, 1'b0},
			'{ACT_NAME,    8'h72, 1,   1'b0, 1'b0, 1'b0},
			'{ACT_NAME,    8'h73, 1,   1'b0, 1'b0, 1'b0},
			'{ACT_NAME,    8'h5A, 1,   1'b0, 1'b0, 1'b0},
			'{ACT_NAME,    8'hFF, 1,   1'b0, 1'b0, 1'b0},
			'{ACT_END,     8'h00, 1,   1'b0, 1'b0, 1'b0},
			// pattern store runs over and the overflow flag rises
			'{ACT_PATTERN, 8'h78, MAX_PATTERN + 6, 1'b0, 1'b0, 1'b0},
			'{ACT_END,     8'h00, 1,   1'b0, 1'b0, 1'b0},
			// clear drops pattern and overflow together
			'{ACT_CLEAR,   8'hFF, 1,   1'b0, 1'b0, 1'b0},
			'{ACT_END,     8'h00, 1,   1'b1, 1'b1, 1'b0},
			// name store runs over, star still matches the truncated name
			'{ACT_PATTERN, CH_ANY, 1,  1'b0, 1'b0, 1'b0},
			'{ACT_NAME,    8'h62, MAX_NAME + 44, 1'b0, 1'b0, 1'b0},
			'{ACT_END,     8'h00, 1,   1'b1, 1'b1, 1'b1},
			// overflow stays up across the next end until a clear
			'{ACT_END,     8'h00, 1,   1'b1, 1'b1, 1'b1},
			// zero bytes compare like any other literal
			'{ACT_CLEAR,   8'h00, 1,   1'b0, 1'b0, 1'b0},
			'{ACT_PATTERN, 8'h00, 1,   1'b0, 1'b0, 1'b0},
			'{ACT_NAME,    8'h00, 1,   1'b0, 1'b0, 1'b0},
			'{ACT_END,     8'hFF, 1,   1'b1, 1'b1, 1'b0}
		};

		// reset held from time zero, released at a falling edge
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		foreach (glob_rows[r]) begin
			repeat (glob_rows[r].reps) begin
				send_item(glob_rows[r].act, glob_rows[r].ch, glob_rows[r].typed,
					glob_rows[r].want_match, glob_rows[r].want_ovf);
			end
		end

		// random sessions in four idling phases; each phase starts from a drained dut
		rand_base = items_sent;
		for (int phase = 0; phase < 4; phase++) begin
			drain_pending();
			case (phase)
				0: begin
					send_idle_pct = 0;
					recv_stall_pct = 0;
				end
				1: begin
					send_idle_pct = 52;
					recv_stall_pct = 0;
				end
				2: begin
					send_idle_pct = 0;
					recv_stall_pct = 52;
				end
				default: begin
					send_idle_pct = 23;
					recv_stall_pct = 23;
				end
			endcase
			phase_end = rand_base + (phase + 1) * RANDOM_ITEMS / 4;
			while (items_sent < phase_end) begin
				run_session();
			end
		end
		item_ch.valid <= 1'b0;

		// let every owed outcome come back, then a quiet stretch for stray results
		while (pending_flags.size() != 0) begin
			@(posedge clk);
		end
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (mismatches == 0) begin
			$display("wildcard_name_match verification clean");
		end else begin
			$display("wildcard_name_match verification failed");
		end
		$finish;
	end

endmodule
